// ===== hdl/als_pkg.sv =====
// Shared types and constants for the Armijo line search sequencer.
// Depends on nothing; used by als_ctrl, als_datapath and the top level.
package als_pkg;

	localparam int STEP_W  = 20;
	localparam int FRAC_W  = 16;
	localparam int OBJ_W   = 32;
	localparam int TRIES_W = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [1:0] KIND_EVAL  = 2'd0;
	localparam logic [1:0] KIND_FINAL = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STEP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_FACTOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ARMIJO_FACTOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_FLOOR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES     = 3'd4;

	localparam logic [STEP_W-1:0]  RST_INITIAL_STEP  = 20'd65536;
	localparam logic [FRAC_W-1:0]  RST_SHRINK_FACTOR = 16'd32768;
	localparam logic [FRAC_W-1:0]  RST_ARMIJO_FACTOR = 16'd7;
	localparam logic [FRAC_W-1:0]  RST_STEP_FLOOR    = 16'd1;
	localparam logic [TRIES_W-1:0] RST_MAX_TRIES     = 7'd20;

	typedef struct packed {
		logic                    operation;
		logic signed [OBJ_W-1:0] objective_now;
		logic [OBJ_W-1:0]        grad_sq;
		logic signed [OBJ_W-1:0] trial_objective;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [STEP_W-1:0]       step;
		logic signed [OBJ_W-1:0] objective;
		logic [TRIES_W-1:0]      backtrack_count;
		logic                    success;
	} out_item_t;

	typedef enum logic [1:0] {
		ASEL_HOLD   = 2'd0,
		ASEL_INIT   = 2'd1,
		ASEL_SHRINK = 2'd2,
		ASEL_FLOOR  = 2'd3
	} alpha_sel_t;

	typedef enum logic [1:0] {
		OSEL_NONE  = 2'd0,
		OSEL_START = 2'd1,
		OSEL_EVAL  = 2'd2,
		OSEL_FINAL = 2'd3
	} out_sel_t;

	typedef struct packed {
		logic       capture;
		logic       mul_en;
		logic       prod_en;
		logic       sum_en;
		logic       cmp_en;
		logic       save_start;
		alpha_sel_t alpha_sel;
		logic       tries_clr;
		logic       tries_inc;
		logic       out_load;
		logic [1:0] out_kind;
		out_sel_t   out_sel;
		logic       out_success;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_op;
		logic op;
		logic g_zero;
		logic max_zero;
		logic holds;
		logic below_floor;
		logic exhausted;
	} dp_stat_t;

endpackage

// ===== hdl/als_datapath.sv =====
// Datapath: configuration registers, search registers, decrease-term multiply
// pipeline, Armijo compare and the output register. Depends on als_pkg.
module als_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [als_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [als_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  als_pkg::in_item_t                  in_data,
	input  als_pkg::ctrl_cmd_t                 cmd,
	output als_pkg::dp_stat_t                  stat,
	output als_pkg::out_item_t                 out_data
);
	import als_pkg::*;

	logic [STEP_W-1:0]  init_step_q;
	logic [FRAC_W-1:0]  shrink_q;
	logic [FRAC_W-1:0]  armijo_q;
	logic [FRAC_W-1:0]  floor_q;
	logic [TRIES_W-1:0] max_tries_q;

	in_item_t                in_q;
	logic signed [OBJ_W-1:0] saved_obj_q;
	logic [OBJ_W-1:0]        saved_grad_q;
	logic [STEP_W-1:0]       alpha_q;
	logic [TRIES_W-1:0]      tries_q;
	out_item_t               out_q;

	logic [35:0]       ca_s1;
	logic [35:0]       shr_s1;
	logic [51:0]       phi_s2;
	logic [35:0]       plo_s2;
	logic [OBJ_W-1:0]  d_s3;
	logic              holds_s4;

	logic [51:0]        plo_c;
	logic [52:0]        sum_c;
	logic [36:0]        dfull_c;
	logic signed [33:0] thr_c;
	logic [STEP_W-1:0]  shrunk_c;
	logic [STEP_W-1:0]  floor_ext_c;
	logic [TRIES_W-1:0] tries_next_c;
	logic [STEP_W-1:0]  alpha_d;
	out_item_t          out_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_step_q <= RST_INITIAL_STEP;
			shrink_q    <= RST_SHRINK_FACTOR;
			armijo_q    <= RST_ARMIJO_FACTOR;
			floor_q     <= RST_STEP_FLOOR;
			max_tries_q <= RST_MAX_TRIES;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INITIAL_STEP:  init_step_q <= cfg_wdata;
				CFG_SHRINK_FACTOR: shrink_q    <= cfg_wdata[FRAC_W-1:0];
				CFG_ARMIJO_FACTOR: armijo_q    <= cfg_wdata[FRAC_W-1:0];
				CFG_STEP_FLOOR:    floor_q     <= cfg_wdata[FRAC_W-1:0];
				CFG_MAX_TRIES:     max_tries_q <= cfg_wdata[TRIES_W-1:0];
				default: ;
			endcase
		end
	end

	assign shrunk_c     = shr_s1[35:16];
	assign floor_ext_c  = {4'b0, floor_q};
	assign tries_next_c = tries_q + 7'd1;

	always_comb begin
		case (cmd.alpha_sel)
			ASEL_INIT:   alpha_d = init_step_q;
			ASEL_SHRINK: alpha_d = shrunk_c;
			ASEL_FLOOR:  alpha_d = floor_ext_c;
			default:     alpha_d = alpha_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_obj_q  <= '0;
			saved_grad_q <= '0;
			alpha_q      <= '0;
			tries_q      <= '0;
		end else begin
			if (cmd.save_start) begin
				saved_obj_q  <= in_q.objective_now;
				saved_grad_q <= in_q.grad_sq;
			end
			alpha_q <= alpha_d;
			if (cmd.tries_clr) begin
				tries_q <= '0;
			end else if (cmd.tries_inc) begin
				tries_q <= tries_next_c;
			end
		end
	end

	assign plo_c   = 52'(ca_s1) * 52'(saved_grad_q[15:0]);
	assign sum_c   = 53'(phi_s2) + 53'(plo_s2);
	assign dfull_c = sum_c[52:16];
	assign thr_c   = 34'(saved_obj_q) - $signed({2'b00, d_s3});

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
		if (cmd.mul_en) begin
			ca_s1  <= 36'(armijo_q) * 36'(alpha_q);
			shr_s1 <= 36'(alpha_q) * 36'(shrink_q);
		end
		if (cmd.prod_en) begin
			phi_s2 <= 52'(ca_s1) * 52'(saved_grad_q[31:16]);
			plo_s2 <= plo_c[51:16];
		end
		if (cmd.sum_en) begin
			d_s3 <= (|dfull_c[36:32]) ? '1 : dfull_c[31:0];
		end
		if (cmd.cmp_en) begin
			holds_s4 <= (34'(in_q.trial_objective) <= thr_c);
		end
		if (cmd.out_load) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		out_d                 = '0;
		out_d.kind            = cmd.out_kind;
		case (cmd.out_sel)
			OSEL_START: begin
				out_d.objective = in_q.objective_now;
				out_d.success   = 1'b1;
			end
			OSEL_EVAL: begin
				out_d.step = alpha_d;
			end
			OSEL_FINAL: begin
				out_d.step            = alpha_q;
				out_d.objective       = in_q.trial_objective;
				out_d.backtrack_count = tries_q;
				out_d.success         = cmd.out_success;
			end
			default: ;
		endcase
	end

	assign stat.in_op       = in_data.operation;
	assign stat.op          = in_q.operation;
	assign stat.g_zero      = (in_q.grad_sq == '0);
	assign stat.max_zero    = (max_tries_q == '0);
	assign stat.holds       = holds_s4;
	assign stat.below_floor = (shrunk_c < floor_ext_c);
	assign stat.exhausted   = (tries_next_c >= max_tries_q);
	assign out_data         = out_q;

endmodule

// ===== hdl/als_ctrl.sv =====
// Controller: item sequencing state machine, search phase and output valid.
// Depends on als_pkg; drives als_datapath through ctrl_cmd_t.
module als_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  als_pkg::dp_stat_t   stat,
	output als_pkg::ctrl_cmd_t  cmd
);
	import als_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_PROD = 6'b000100,
		ST_SUM  = 6'b001000,
		ST_CMP  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_TRY   = 4'b0010,
		PH_FLOOR = 4'b0100,
		PH_LAST  = 4'b1000
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		cmd           = '0;
		cmd.alpha_sel = ASEL_HOLD;
		cmd.out_sel   = OSEL_NONE;
		cmd.out_kind  = KIND_ERR;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (stat.in_op && (phase_q inside {PH_TRY, PH_FLOOR})) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod_en = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp_en = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
					if (!stat.op) begin
						if (phase_q != PH_IDLE) begin
							cmd.out_kind = KIND_ERR;
						end else if (stat.g_zero) begin
							cmd.out_kind = KIND_FINAL;
							cmd.out_sel  = OSEL_START;
						end else begin
							cmd.save_start = 1'b1;
							cmd.alpha_sel  = ASEL_INIT;
							cmd.tries_clr  = 1'b1;
							cmd.out_kind   = KIND_EVAL;
							cmd.out_sel    = OSEL_EVAL;
							phase_d        = stat.max_zero ? PH_LAST : PH_TRY;
						end
					end else begin
						case (phase_q)
							PH_LAST: begin
								cmd.out_kind = KIND_FINAL;
								cmd.out_sel  = OSEL_FINAL;
								phase_d      = PH_IDLE;
							end
							PH_FLOOR: begin
								cmd.out_kind    = KIND_FINAL;
								cmd.out_sel     = OSEL_FINAL;
								cmd.out_success = stat.holds;
								phase_d         = PH_IDLE;
							end
							PH_TRY: begin
								if (stat.holds) begin
									cmd.out_kind    = KIND_FINAL;
									cmd.out_sel     = OSEL_FINAL;
									cmd.out_success = 1'b1;
									phase_d         = PH_IDLE;
								end else begin
									cmd.tries_inc = 1'b1;
									cmd.out_kind  = KIND_EVAL;
									cmd.out_sel   = OSEL_EVAL;
									if (stat.below_floor) begin
										cmd.alpha_sel = ASEL_FLOOR;
										phase_d       = PH_FLOOR;
									end else begin
										cmd.alpha_sel = ASEL_SHRINK;
										phase_d       = stat.exhausted ? PH_LAST : PH_TRY;
									end
								end
							end
							default: begin
								cmd.out_kind = KIND_ERR;
							end
						endcase
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending transaction");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");

	a_mul_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (phase_q == PH_TRY || phase_q == PH_FLOOR))
		else $error("decrease term computed outside a trial phase");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_PROD) ##1 (state_q == ST_SUM)
			##1 (state_q == ST_CMP) ##1 (state_q == ST_OUT))
		else $error("compare pipeline out of sequence");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second transaction accepted while one is in work");

endmodule

// ===== hdl/armijo_line_search_sequencer.sv =====
// Sequencing: a start, an error or a last-phase trial answer goes from acceptance
// straight to the output state; a trial answer in a trial or floor phase first
// passes the multiply, partial product, sum and compare steps of the datapath.
// Throughput: one transaction in work at a time, until its result is loaded.
// Reset: configuration registers take their defaults and the search goes idle
// at once; no clearing pass.
module armijo_line_search_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [als_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [als_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  als_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output als_pkg::out_item_t              out_data
);
	import als_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	als_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	als_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule
